// ----- src/lsb_marker_framed_extract_macros.svh -----
// Assertion macros shared by the lsb_marker_framed_extract RTL.
// No dependencies; included inside module bodies that check their own logic.
`ifndef LSB_MARKER_FRAMED_EXTRACT_MACROS_SVH
`define LSB_MARKER_FRAMED_EXTRACT_MACROS_SVH

// Implication or plain property, checked on the rising clock, off in reset.
`define LMFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define LMFE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/lmfe_pkg.sv -----
// Shared types and constants for the lsb_marker_framed_extract block.
// No dependencies.
package lmfe_pkg;

    // Configuration register indexes
    localparam logic CFG_MARKER_LENGTH = 1'b0;
    localparam logic CFG_MARKER_BYTES  = 1'b1;

    localparam logic [3:0] MARKER_LENGTH_RESET = 4'd8;

    // Result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_CLOSE   = 2'd1;
    localparam logic [1:0] KIND_ABANDON = 2'd2;

    // Run queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
    } t_result;

    // All results caused by one pixel: one or two
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_run;

    // LSBs of alpha, red, green, blue
    function automatic logic [3:0] lsb_nibble(input logic [31:0] pixel);
        lsb_nibble = {pixel[24], pixel[16], pixel[8], pixel[0]};
    endfunction

endpackage

// ----- src/lsb_marker_framed_extract.sv -----
// lsb_marker_framed_extract: recovers one byte from every two ARGB pixels (LSBs
// of A, R, G, B; first pixel gives the high nibble) and forwards only the bytes
// framed by a configurable marker of 1..MARKER_MAX bytes. Each message ends
// with a "complete" result; an image that ends inside a message gives an
// "abandoned" result. Message bytes leave marker-length bytes late, so the
// closing marker never appears. Rate: one pixel per cycle while full is low. A
// pixel causes zero, one or two results; these form one run in a four-entry
// queue, and results leave one per cycle while pop is high and empty is low.
// full rises only when that queue holds four runs. A pixel's run is registered
// into the queue and reaches the outputs when at its head. There is no clearing
// pass after reset. Config writes take effect at once and are meant for idle
// periods. Depends on lmfe_pkg, lmfe_front, lmfe_queue, lmfe_back.
module lsb_marker_framed_extract #(
    parameter int MARKER_MAX = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port: index 0 marker_length, 1 marker_bytes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // pixel side
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_pixel,
    input  logic        i_end_of_image,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_kind,
    output logic        o_final_of_run
);
    import lmfe_pkg::*;

    logic accept;      // pixel transfer this cycle
    logic run_push;    // pixel produced at least one result
    t_run run;
    t_run head;
    logic q_full;
    logic q_empty;
    logic deq;         // last result of head run transferred

    assign full   = q_full;
    assign accept = push && !q_full;

    lmfe_front #(
        .MARKER_MAX(MARKER_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_pixel        (i_pixel),
        .i_end_of_image (i_end_of_image),
        .o_push         (run_push),
        .o_run          (run)
    );

    lmfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (run_push),
        .i_run   (run),
        .i_pop   (deq),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lmfe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_empty      (q_empty),
        .i_pop          (pop),
        .o_deq          (deq),
        .o_empty        (empty),
        .o_data_byte    (o_data_byte),
        .o_kind         (o_kind),
        .o_final_of_run (o_final_of_run)
    );

endmodule

// ----- src/lmfe_front.sv -----
// Front part: config registers, byte assembly, marker window and framing state.
// Depends on lmfe_pkg and lsb_marker_framed_extract_macros.svh.
module lmfe_front #(
    parameter int MARKER_MAX = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [63:0]    i_cfg_data,
    input  logic           i_accept,
    input  logic [31:0]    i_pixel,
    input  logic           i_end_of_image,
    output logic           o_push,
    output lmfe_pkg::t_run o_run
);
    import lmfe_pkg::*;
    `include "lsb_marker_framed_extract_macros.svh"

    localparam int LW = $clog2(MARKER_MAX + 2);
    localparam int IW = (MARKER_MAX > 1) ? $clog2(MARKER_MAX) : 1;

    logic [3:0]    r_len;
    logic [63:0]   r_mbytes;
    logic          r_phase,  n_phase;
    logic [3:0]    r_upper,  n_upper;
    logic [7:0]    r_win [MARKER_MAX];
    logic [7:0]    n_win [MARKER_MAX];
    logic [LW-1:0] r_seen,   n_seen;
    logic [LW-1:0] r_since,  n_since;
    logic          r_inside, n_inside;

    logic [7:0]    mk [MARKER_MAX];
    logic [LW-1:0] eff_len;
    logic [LW-1:0] len_plus1;
    logic [LW-1:0] pos;
    logic [IW-1:0] oldest_idx;
    logic [3:0]    nib;
    logic          match;
    logic          e_byte, e_close, e_abandon;

    // marker characters; positions beyond the 64-bit register read as zero
    for (genvar k = 0; k < MARKER_MAX; k++) begin : g_mk
        if (k < 8) begin : g_reg
            assign mk[k] = r_mbytes[8*k +: 8];
        end else begin : g_zero
            assign mk[k] = 8'd0;
        end
    end

    // 0 acts as 1, above MARKER_MAX acts as MARKER_MAX
    always_comb begin
        if (r_len == 4'd0) begin
            eff_len = LW'(1);
        end else if (int'(r_len) > MARKER_MAX) begin
            eff_len = LW'(MARKER_MAX);
        end else begin
            eff_len = LW'(r_len);
        end
    end

    assign len_plus1  = eff_len + LW'(1);
    assign oldest_idx = IW'(eff_len - LW'(1));
    assign nib        = lsb_nibble(i_pixel);

    always_comb begin
        n_phase   = r_phase;
        n_upper   = r_upper;
        n_win     = r_win;
        n_seen    = r_seen;
        n_since   = r_since;
        n_inside  = r_inside;
        e_byte    = 1'b0;
        e_close   = 1'b0;
        e_abandon = 1'b0;
        match     = 1'b0;
        pos       = '0;
        if (!r_phase) begin
            n_upper = nib;
            n_phase = 1'b1;
        end else begin
            n_phase = 1'b0;
            n_upper = 4'd0;
            e_byte  = r_inside && (r_since >= eff_len);
            n_win[0] = {r_upper, nib};
            for (int j = 1; j < MARKER_MAX; j++) begin
                n_win[j] = r_win[j-1];
            end
            if (r_seen < eff_len) n_seen = r_seen + LW'(1);
            if (r_inside && (r_since < len_plus1)) n_since = r_since + LW'(1);
            // newest byte sits at 0, so window entry j meets marker char L-1-j
            match = (n_seen >= eff_len);
            for (int j = 0; j < MARKER_MAX; j++) begin
                pos = eff_len - LW'(j) - LW'(1);
                if ((LW'(j) < eff_len) && (n_win[j] != mk[pos[IW-1:0]])) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                if (r_inside) begin
                    n_inside = 1'b0;
                    e_close  = 1'b1;
                end else begin
                    n_inside = 1'b1;
                    n_since  = '0;
                end
            end
        end
        if (i_end_of_image) begin
            e_abandon = n_inside;
            n_phase   = 1'b0;
            n_upper   = 4'd0;
            for (int j = 0; j < MARKER_MAX; j++) begin
                n_win[j] = 8'd0;
            end
            n_seen   = '0;
            n_since  = '0;
            n_inside = 1'b0;
        end
    end

    // pack the pixel's results in order: byte, then close or abandon
    always_comb begin
        o_run.two            = e_byte && (e_close || e_abandon);
        o_run.res1.data_byte = 8'd0;
        o_run.res1.kind      = e_close ? KIND_CLOSE : KIND_ABANDON;
        if (e_byte) begin
            o_run.res0.data_byte = r_win[oldest_idx];
            o_run.res0.kind      = KIND_BYTE;
        end else begin
            o_run.res0.data_byte = 8'd0;
            o_run.res0.kind      = e_close ? KIND_CLOSE : KIND_ABANDON;
        end
    end

    assign o_push = i_accept && (e_byte || e_close || e_abandon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= MARKER_LENGTH_RESET;
            r_mbytes <= 64'd0;
            r_phase  <= 1'b0;
            r_upper  <= 4'd0;
            for (int j = 0; j < MARKER_MAX; j++) begin
                r_win[j] <= 8'd0;
            end
            r_seen   <= '0;
            r_since  <= '0;
            r_inside <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MARKER_LENGTH: r_len    <= i_cfg_data[3:0];
                    CFG_MARKER_BYTES:  r_mbytes <= i_cfg_data;
                    default:           r_len    <= r_len;
                endcase
            end
            if (i_accept) begin
                r_phase  <= n_phase;
                r_upper  <= n_upper;
                r_win    <= n_win;
                r_seen   <= n_seen;
                r_since  <= n_since;
                r_inside <= n_inside;
            end
        end
    end

    `LMFE_ASSERT(a_eoi_clears, i_clk, i_rst_n, (i_accept && i_end_of_image) |=> (!r_phase && !r_inside && r_seen == '0), "stream state not cleared after end of image")
    `LMFE_ASSERT(a_seen_bound, i_clk, i_rst_n, r_seen <= LW'(MARKER_MAX), "bytes_seen above marker maximum")
    `LMFE_ASSERT(a_two_byte_first, i_clk, i_rst_n, (o_push && o_run.two) |-> (o_run.res0.kind == KIND_BYTE), "two-result run must lead with a byte")

endmodule

// ----- src/lmfe_queue.sv -----
// Short run queue that decouples the front part from the result side.
// Depends on lmfe_pkg and lsb_marker_framed_extract_macros.svh.
module lmfe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lmfe_pkg::t_run i_run,
    input  logic           i_pop,
    output lmfe_pkg::t_run o_head,
    output logic           o_full,
    output logic           o_empty
);
    import lmfe_pkg::*;
    `include "lsb_marker_framed_extract_macros.svh"

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + QPTR_W'(1);
            if (do_pop)  r_rptr <= r_rptr + QPTR_W'(1);
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `LMFE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
    `LMFE_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "run pushed into a full queue")
    `LMFE_ASSERT(a_pop_count, i_clk, i_rst_n, (do_pop && !do_push) |=> (r_count == $past(r_count) - QCNT_W'(1)), "count did not drop on pop")

endmodule

// ----- src/lmfe_back.sv -----
// Back part: hands out the one or two results of the oldest queued run.
// Depends on lmfe_pkg.
module lmfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lmfe_pkg::t_run i_head,
    input  logic           i_q_empty,
    input  logic           i_pop,
    output logic           o_deq,
    output logic           o_empty,
    output logic [7:0]     o_data_byte,
    output logic [1:0]     o_kind,
    output logic           o_final_of_run
);
    import lmfe_pkg::*;

    logic    r_second;
    logic    last_of_run;
    logic    taken;
    t_result cur;

    assign cur            = r_second ? i_head.res1 : i_head.res0;
    assign last_of_run    = r_second || !i_head.two;
    assign taken          = i_pop && !i_q_empty;
    assign o_deq          = taken && last_of_run;
    assign o_empty        = i_q_empty;
    assign o_data_byte    = cur.data_byte;
    assign o_kind         = cur.kind;
    assign o_final_of_run = last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (taken) begin
            r_second <= !last_of_run;
        end
    end

endmodule

// ----- sim/lmfe_checker.sv -----
// Checker for lsb_marker_framed_extract: watches config writes and both queue sides,
// predicts the results of every pixel transfer and compares them in order.
// Depends on lmfe_pkg.
module lmfe_checker #(
    parameter int MARKER_MAX = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [31:0] i_pixel,
    input  logic        i_end_of_image,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_data_byte,
    input  logic [1:0]  i_kind,
    input  logic        i_final_of_run,
    output int          o_mismatches,
    output int          o_results_waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import lmfe_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
        logic       final_of_run;
    } t_exp_result;

    t_exp_result expected_results[$];

    // register copies
    logic [3:0]  len_reg;
    logic [63:0] marker_reg;

    // stream state, window[0] newest
    logic        odd_pixel;
    logic [3:0]  high_nib;
    logic [7:0]  window [MARKER_MAX];
    int          bytes_seen;
    int          since_open;
    logic        in_msg;

    initial o_mismatches = 0;

    task automatic clear_stream();
        odd_pixel  = 1'b0;
        high_nib   = '0;
        for (int k = 0; k < MARKER_MAX; k++) window[k] = '0;
        bytes_seen = 0;
        since_open = 0;
        in_msg     = 1'b0;
    endtask

    task automatic recover_pixel(input logic [31:0] px, input logic eoi);
        logic [3:0]  nib;
        logic [7:0]  rebuilt;
        logic [7:0]  mk;
        int          eff;
        int          n;
        bit          hit;
        t_exp_result run [2];
        nib = {px[24], px[16], px[8], px[0]};
        n   = 0;
        if (!odd_pixel) begin
            high_nib  = nib;
            odd_pixel = 1'b1;
        end else begin
            eff = (len_reg == 0) ? 1 : ((len_reg > MARKER_MAX) ? MARKER_MAX : int'(len_reg));
            rebuilt   = {high_nib, nib};
            odd_pixel = 1'b0;
            high_nib  = '0;
            // oldest window byte leaves once the marker has fully passed
            if (in_msg && since_open >= eff) begin
                run[n] = '{window[eff-1], KIND_BYTE, 1'b0};
                n++;
            end
            for (int k = MARKER_MAX - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = rebuilt;
            if (bytes_seen < eff) bytes_seen++;
            if (in_msg && since_open < eff + 1) since_open++;
            hit = (bytes_seen >= eff);
            for (int k = 0; k < eff; k++) begin
                mk = (k < 8) ? marker_reg[8*k +: 8] : 8'h00;
                if (window[eff-1-k] != mk) hit = 1'b0;
            end
            if (hit) begin
                if (in_msg) begin
                    in_msg = 1'b0;
                    run[n] = '{8'h00, KIND_CLOSE, 1'b0};
                    n++;
                end else begin
                    in_msg     = 1'b1;
                    since_open = 0;
                end
            end
        end
        if (eoi) begin
            if (in_msg) begin
                run[n] = '{8'h00, KIND_ABANDON, 1'b0};
                n++;
            end
            clear_stream();
        end
        for (int k = 0; k < n; k++) begin
            run[k].final_of_run = (k == n - 1);
            expected_results.push_back(run[k]);
        end
    endtask

    task automatic check_result();
        t_exp_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got byte %02h kind %0d final %0b",
                     $time, i_data_byte, i_kind, i_final_of_run);
            o_mismatches++;
        end else begin
            want = expected_results.pop_front();
            if (i_data_byte !== want.data_byte) begin
                $display("%0t: data_byte mismatch, expected %02h, got %02h",
                         $time, want.data_byte, i_data_byte);
                o_mismatches++;
            end
            if (i_kind !== want.kind) begin
                $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, i_kind);
                o_mismatches++;
            end
            if (i_final_of_run !== want.final_of_run) begin
                $display("%0t: final_of_run mismatch, expected %0b, got %0b",
                         $time, want.final_of_run, i_final_of_run);
                o_mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg    = MARKER_LENGTH_RESET;
            marker_reg = '0;
            clear_stream();
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) check_result();
            // a pixel at the same edge as a write still sees the old registers
            if (i_push && !i_full) recover_pixel(i_pixel, i_end_of_image);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MARKER_LENGTH) len_reg = i_cfg_data[3:0];
                else marker_reg = i_cfg_data;
            end
        end
        o_results_waiting <= expected_results.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top-level testbench for lsb_marker_framed_extract: clock, reset, pixel and
// config stimulus, result-side stalls, watchdog and verdict.
// Depends on lmfe_pkg, lmfe_checker and the block's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lmfe_pkg::*;

    localparam int          RANDOM_PIXELS = 2000;
    localparam int          LONG_HOLD     = 200;   // receiver hold-off, fills the run queue
    localparam int          STALL_LIMIT   = 3000;  // cycles without any transfer or register write
    localparam logic [31:0] LSB_MASK      = 32'h0101_0101;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [31:0] i_pixel;
    logic        i_end_of_image;
    logic        empty;
    logic        pop;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_kind;
    logic        o_final_of_run;

    int          mismatches;
    int          results_waiting;

    // stimulus-side copy of the registers, used to build marker sequences
    logic [3:0]  cur_len;
    logic [63:0] cur_marker;
    int          burst_left;
    int          pixels_sent;
    int          idle_cycles = 0;
    logic [31:0] frame_px[$];

    lsb_marker_framed_extract uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_pixel        (i_pixel),
        .i_end_of_image (i_end_of_image),
        .empty          (empty),
        .pop            (pop),
        .o_data_byte    (o_data_byte),
        .o_kind         (o_kind),
        .o_final_of_run (o_final_of_run)
    );

    lmfe_checker chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_push            (push),
        .i_full            (full),
        .i_pixel           (i_pixel),
        .i_end_of_image    (i_end_of_image),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_data_byte       (o_data_byte),
        .i_kind            (o_kind),
        .i_final_of_run    (o_final_of_run),
        .o_mismatches      (mismatches),
        .o_results_waiting (results_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: segments of free flow, random stalls or sparse pops, and every
    // twelfth segment a long hold-off so the run queue fills and full rises.
    initial begin
        int seg;
        int mode;
        pop = 1'b0;
        seg = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            seg++;
            if (seg % 12 == 4) begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 2);
                repeat ($urandom_range(10, 120)) begin
                    case (mode)
                        0:       pop <= 1'b1;
                        1:       pop <= 1'($urandom_range(0, 1));
                        default: pop <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: any transfer or register write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL lsb_marker_framed_extract");
            $finish;
        end
    end

    function automatic int eff_len();
        if (cur_len == 0) return 1;
        if (cur_len > 8) return 8;
        return int'(cur_len);
    endfunction

    // Hide one nibble in the LSBs of A, R, G, B; the other bits come from fill.
    function automatic logic [31:0] stego_pixel(input logic [3:0] nib, input logic [31:0] fill);
        return (fill & ~LSB_MASK) |
               {7'b0, nib[3], 7'b0, nib[2], 7'b0, nib[1], 7'b0, nib[0]};
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic [31:0] fill);
        frame_px.push_back(stego_pixel(b[7:4], fill));
        frame_px.push_back(stego_pixel(b[3:0], ~fill));
    endtask

    task automatic add_marker();
        for (int k = 0; k < eff_len(); k++) add_byte(cur_marker[8*k +: 8], $urandom());
    endtask

    // Both registers are written back to back; the enable drops once at the end.
    task automatic write_markers(input logic [3:0] len, input logic [63:0] marker);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MARKER_LENGTH;
        i_cfg_data  <= {junk[63:4], len};   // upper bits are don't-care
        @(posedge i_clk);
        i_cfg_index <= CFG_MARKER_BYTES;
        i_cfg_data  <= marker;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_len    = len;
        cur_marker = marker;
    endtask

    // One pixel transfer. The sender runs in bursts; at the end of a burst push
    // drops for a random gap before the next pixel.
    task automatic send_pixel(input logic [31:0] px, input logic eoi);
        i_pixel        <= px;
        i_end_of_image <= eoi;
        push           <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic terminate);
        for (int k = 0; k < frame_px.size(); k++)
            send_pixel(frame_px[k], terminate && (k == frame_px.size() - 1));
        pixels_sent += frame_px.size();
        frame_px.delete();
    endtask

    // Sender pause: wait until every predicted result has been popped, then wait
    // on while pixels that caused none clear the pipeline.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (results_waiting != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Noise bytes, up to two framed messages (some never closed), noise, and
    // sometimes a dangling half byte before the end of the image.
    task automatic build_image();
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)), $urandom());
        repeat ($urandom_range(0, 2)) begin
            add_marker();
            repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(0, 255)), $urandom());
            if ($urandom_range(0, 3) != 0) add_marker();
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), $urandom());
        end
        if ($urandom_range(0, 3) == 0) frame_px.push_back($urandom());
    endtask

    initial begin
        int          phase_no;
        int          phase_end;
        logic [3:0]  len_pick;
        logic [63:0] marker_pick;
        logic [7:0]  byte_pick;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_MARKER_LENGTH;
        i_cfg_data     = '0;
        push           = 1'b0;
        i_pixel        = '0;
        i_end_of_image = 1'b0;
        cur_len        = MARKER_LENGTH_RESET;
        cur_marker     = '0;
        burst_left     = $urandom_range(1, 30);
        pixels_sent    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // One-byte marker: open, one byte, close (byte and close from one pixel),
        // then reopen and end the image inside the message (byte then abandon).
        // Fill alternates all-zero and all-one pixel bits.
        write_markers(4'd1, {$urandom(), 24'($urandom_range(0, 16777215)), 8'h7E});
        add_byte(8'h7E, 32'h0000_0000);
        add_byte(8'hFF, 32'hFFFF_FFFF);
        add_byte(8'h7E, 32'h0000_0000);
        add_byte(8'h7E, 32'hFFFF_FFFF);
        add_byte(8'h11, 32'h0000_0000);
        add_byte(8'h22, 32'hFFFF_FFFF);
        send_frame(1'b1);
        // image of a single pixel: half byte dropped at image end
        frame_px.push_back($urandom());
        send_frame(1'b1);
        drain();
        // Repeating marker: the third byte closes a message that overlaps its
        // own opening, so only the close is reported.
        write_markers(4'd2, {$urandom(), 16'($urandom()), 16'hAAAA});
        add_byte(8'hAA, $urandom());
        add_byte(8'hAA, $urandom());
        add_byte(8'hAA, $urandom());
        send_frame(1'b0);
        drain();
        // Register change mid-image, length above range acts as the maximum;
        // the window keeps its contents.
        write_markers(4'd15, {$urandom(), $urandom()});
        add_byte(8'($urandom_range(0, 255)), $urandom());
        frame_px.push_back($urandom());
        send_frame(1'b1);
        drain();

        // --- random ---
        pixels_sent = 0;
        phase_no    = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            drain();
            case (phase_no)
                0:       len_pick = 4'd0;   // acts as one
                1:       len_pick = 4'd15;  // acts as the maximum
                2:       len_pick = 4'd8;
                3:       len_pick = 4'd1;
                default: len_pick = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                                : 4'($urandom_range(1, 8));
            endcase
            byte_pick = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 5))
                0:       marker_pick = {8{byte_pick}};   // self-overlapping marker
                1:       marker_pick = '0;
                2:       marker_pick = '1;
                default: marker_pick = {$urandom(), $urandom()};
            endcase
            write_markers(len_pick, marker_pick);
            phase_end = pixels_sent + $urandom_range(80, 250);
            while (pixels_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 30)) frame_px.push_back($urandom());
                end else begin
                    build_image();
                end
                send_frame(1'b1);
            end
            // sometimes leave an open message across the next register change
            if ($urandom_range(0, 3) == 0) begin
                add_marker();
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)), $urandom());
                if ($urandom_range(0, 1) == 0) frame_px.push_back($urandom());
                send_frame(1'b0);
            end
            phase_no++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && results_waiting == 0) begin
            $display("PASS lsb_marker_framed_extract");
        end else begin
            $display("FAIL lsb_marker_framed_extract");
        end
        $finish;
    end

endmodule
